FILE: hdl/lrast_pkg.sv
// Shared types and constants for the line rasterizer.
// No dependencies; used by lrast_core and line_rasterizer.
package lrast_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COLOR_W = 16;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_e;

  typedef struct packed {
    logic valid_res;
    logic last;
  } pix_flags_t;

endpackage

FILE: hdl/lrast_core.sv
// One Bresenham pass: line setup or step, pixel address and next line state.
// Purely combinational; uses lrast_pkg.
module lrast_core #(
  parameter int unsigned COORD_BITS = 9,
  parameter int unsigned ROW_SHIFT  = 10
) (
  input  logic                               func_i,
  input  logic [COORD_BITS-1:0]              start_x_i,
  input  logic [COORD_BITS-1:0]              start_y_i,
  input  logic [COORD_BITS-1:0]              end_x_i,
  input  logic [COORD_BITS-1:0]              end_y_i,
  input  logic [lrast_pkg::COLOR_W-1:0]      color_i,
  input  logic [lrast_pkg::ADDR_W-1:0]       frame_base_i,
  // current line state
  input  logic                               active_i,
  input  logic                               steep_i,
  input  logic [COORD_BITS-1:0]              major_pos_i,
  input  logic [COORD_BITS-1:0]              major_end_i,
  input  logic [COORD_BITS-1:0]              minor_pos_i,
  input  logic [COORD_BITS-1:0]              major_delta_i,
  input  logic [COORD_BITS-1:0]              minor_delta_i,
  input  logic                               minor_down_i,
  input  logic signed [COORD_BITS+1:0]       error_term_i,
  input  logic [lrast_pkg::COLOR_W-1:0]      line_colour_i,
  // next line state
  output logic                               active_o,
  output logic                               steep_o,
  output logic [COORD_BITS-1:0]              major_pos_o,
  output logic [COORD_BITS-1:0]              major_end_o,
  output logic [COORD_BITS-1:0]              minor_pos_o,
  output logic [COORD_BITS-1:0]              major_delta_o,
  output logic [COORD_BITS-1:0]              minor_delta_o,
  output logic                               minor_down_o,
  output logic signed [COORD_BITS+1:0]       error_term_o,
  output logic [lrast_pkg::COLOR_W-1:0]      line_colour_o,
  // pixel
  output lrast_pkg::pix_flags_t              flags_o,
  output logic [COORD_BITS-1:0]              pixel_x_o,
  output logic [COORD_BITS-1:0]              pixel_y_o,
  output logic [lrast_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic [lrast_pkg::ADDR_W-1:0]       pixel_address_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;
  localparam int unsigned AW = lrast_pkg::ADDR_W;

  logic [CW-1:0] span_x, span_y;
  logic          su_steep;
  logic [CW-1:0] a1, b1, c1, d1;
  logic [CW-1:0] a2, b2, c2, d2;
  logic [CW-1:0] su_delta, su_mdelta;

  logic                 act;
  logic                 c_steep;
  logic [CW-1:0]        c_major, c_end, c_minor, c_delta, c_mdelta;
  logic                 c_down;
  logic signed [EW-1:0] c_err;
  logic [lrast_pkg::COLOR_W-1:0] c_colour;

  logic [CW-1:0]        x, y;
  logic                 fin;
  logic signed [EW-1:0] err_sum;
  logic                 err_pos;
  logic [AW-1:0]        x_ext, y_ext;

  // setup: steepness, axis swap, ascending major axis
  always_comb begin
    span_x    = (end_x_i > start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    span_y    = (end_y_i > start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    su_steep  = span_y > span_x;
    a1        = su_steep ? start_y_i : start_x_i;
    b1        = su_steep ? start_x_i : start_y_i;
    c1        = su_steep ? end_y_i   : end_x_i;
    d1        = su_steep ? end_x_i   : end_y_i;
    if (a1 > c1) begin
      a2 = c1; b2 = d1; c2 = a1; d2 = b1;
    end else begin
      a2 = a1; b2 = b1; c2 = c1; d2 = d1;
    end
    su_delta  = c2 - a2;
    su_mdelta = (d2 > b2) ? d2 - b2 : b2 - d2;
  end

  // pick freshly set up line or the stored one
  always_comb begin
    if (func_i == lrast_pkg::FUNC_START) begin
      act      = 1'b1;
      c_steep  = su_steep;
      c_major  = a2;
      c_end    = c2;
      c_minor  = b2;
      c_delta  = su_delta;
      c_mdelta = su_mdelta;
      c_down   = !(b2 < d2);
      c_err    = -$signed({2'b00, su_delta >> 1});
      c_colour = color_i;
    end else begin
      act      = active_i;
      c_steep  = steep_i;
      c_major  = major_pos_i;
      c_end    = major_end_i;
      c_minor  = minor_pos_i;
      c_delta  = major_delta_i;
      c_mdelta = minor_delta_i;
      c_down   = minor_down_i;
      c_err    = error_term_i;
      c_colour = line_colour_i;
    end
  end

  always_comb begin
    x       = c_steep ? c_minor : c_major;
    y       = c_steep ? c_major : c_minor;
    fin     = (c_major == c_end);
    x_ext   = {{(AW-CW){1'b0}}, x};
    y_ext   = {{(AW-CW){1'b0}}, y};
    err_sum = c_err + $signed({2'b00, c_mdelta});
    // tie at zero does not advance the minor axis
    err_pos = !err_sum[EW-1] && (err_sum != '0);

    steep_o       = c_steep;
    major_end_o   = c_end;
    major_delta_o = c_delta;
    minor_delta_o = c_mdelta;
    minor_down_o  = c_down;
    line_colour_o = c_colour;
    active_o      = act && !fin;
    major_pos_o   = c_major;
    minor_pos_o   = c_minor;
    error_term_o  = c_err;
    if (act && !fin) begin
      major_pos_o = c_major + CW'(1);
      if (err_pos) begin
        minor_pos_o  = c_down ? c_minor - CW'(1) : c_minor + CW'(1);
        error_term_o = err_sum - $signed({2'b00, c_delta});
      end else begin
        error_term_o = err_sum;
      end
    end
  end

  always_comb begin
    if (act) begin
      flags_o.valid_res = 1'b1;
      flags_o.last      = fin;
      pixel_x_o         = x;
      pixel_y_o         = y;
      pixel_color_o     = c_colour;
      pixel_address_o   = frame_base_i + (y_ext << ROW_SHIFT) + (x_ext << 1);
    end else begin
      flags_o.valid_res = 1'b0;
      flags_o.last      = 1'b0;
      pixel_x_o         = '0;
      pixel_y_o         = '0;
      pixel_color_o     = '0;
      pixel_address_o   = '0;
    end
  end

endmodule

FILE: hdl/line_rasterizer.sv
// Top level of the Bresenham line rasterizer: handshakes, registers, line state.
// Depends on lrast_pkg and lrast_core.
//
// A start transfer (func 0) sets up a line from two endpoints and returns its first
// pixel; each step transfer (func 1) returns the next pixel, with last set on the
// final endpoint, and a step with no line in progress returns valid_res = 0 and
// zero fields. One item is taken per clock unless the output stalls; each result
// passes an input register and then a result register after its input transfer. Setup,
// the error-term update and the address add for one item form a single
// combinational pass between those registers, and the line state is written in
// the same cycle, so the next item follows at once. frame_base is written over
// its own channel, which is always ready.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 9,
  parameter int unsigned ROW_SHIFT  = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrast_pkg::ADDR_W-1:0]   cfg_frame_base_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [COORD_BITS-1:0]          start_x_i,
  input  logic [COORD_BITS-1:0]          start_y_i,
  input  logic [COORD_BITS-1:0]          end_x_i,
  input  logic [COORD_BITS-1:0]          end_y_i,
  input  logic [lrast_pkg::COLOR_W-1:0]  color_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           valid_res_o,
  output logic [COORD_BITS-1:0]          pixel_x_o,
  output logic [COORD_BITS-1:0]          pixel_y_o,
  output logic [lrast_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic [lrast_pkg::ADDR_W-1:0]   pixel_address_o,
  output logic                           last_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 2;

  logic [lrast_pkg::ADDR_W-1:0] frame_base_q;

  // input register
  logic                          in_valid_q;
  logic                          func_q;
  logic [CW-1:0]                 start_x_q, start_y_q, end_x_q, end_y_q;
  logic [lrast_pkg::COLOR_W-1:0] color_q;

  // line state
  logic                          active_q, active_d;
  logic                          steep_q, steep_d;
  logic [CW-1:0]                 major_pos_q, major_pos_d;
  logic [CW-1:0]                 major_end_q, major_end_d;
  logic [CW-1:0]                 minor_pos_q, minor_pos_d;
  logic [CW-1:0]                 major_delta_q, major_delta_d;
  logic [CW-1:0]                 minor_delta_q, minor_delta_d;
  logic                          minor_down_q, minor_down_d;
  logic signed [EW-1:0]          error_term_q, error_term_d;
  logic [lrast_pkg::COLOR_W-1:0] line_colour_q, line_colour_d;

  // result register
  logic                          out_valid_q;
  lrast_pkg::pix_flags_t         flags_q, flags_d;
  logic [CW-1:0]                 pixel_x_q, pixel_x_d;
  logic [CW-1:0]                 pixel_y_q, pixel_y_d;
  logic [lrast_pkg::COLOR_W-1:0] pixel_color_q, pixel_color_d;
  logic [lrast_pkg::ADDR_W-1:0]  pixel_address_q, pixel_address_d;

  logic advance;
  logic fire;
  logic in_xfer;

  assign cfg_ready_o = 1'b1;
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !in_valid_q || advance;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign fire        = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      frame_base_q <= cfg_frame_base_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q    <= func_i;
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
      end_x_q   <= end_x_i;
      end_y_q   <= end_y_i;
      color_q   <= color_i;
    end
  end

  lrast_core #(
    .COORD_BITS (COORD_BITS),
    .ROW_SHIFT  (ROW_SHIFT)
  ) u_core (
    .func_i          (func_q),
    .start_x_i       (start_x_q),
    .start_y_i       (start_y_q),
    .end_x_i         (end_x_q),
    .end_y_i         (end_y_q),
    .color_i         (color_q),
    .frame_base_i    (frame_base_q),
    .active_i        (active_q),
    .steep_i         (steep_q),
    .major_pos_i     (major_pos_q),
    .major_end_i     (major_end_q),
    .minor_pos_i     (minor_pos_q),
    .major_delta_i   (major_delta_q),
    .minor_delta_i   (minor_delta_q),
    .minor_down_i    (minor_down_q),
    .error_term_i    (error_term_q),
    .line_colour_i   (line_colour_q),
    .active_o        (active_d),
    .steep_o         (steep_d),
    .major_pos_o     (major_pos_d),
    .major_end_o     (major_end_d),
    .minor_pos_o     (minor_pos_d),
    .major_delta_o   (major_delta_d),
    .minor_delta_o   (minor_delta_d),
    .minor_down_o    (minor_down_d),
    .error_term_o    (error_term_d),
    .line_colour_o   (line_colour_d),
    .flags_o         (flags_d),
    .pixel_x_o       (pixel_x_d),
    .pixel_y_o       (pixel_y_d),
    .pixel_color_o   (pixel_color_d),
    .pixel_address_o (pixel_address_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      major_pos_q   <= '0;
      major_end_q   <= '0;
      minor_pos_q   <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      minor_down_q  <= 1'b0;
      error_term_q  <= '0;
      line_colour_q <= '0;
    end else if (fire) begin
      active_q      <= active_d;
      steep_q       <= steep_d;
      major_pos_q   <= major_pos_d;
      major_end_q   <= major_end_d;
      minor_pos_q   <= minor_pos_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      minor_down_q  <= minor_down_d;
      error_term_q  <= error_term_d;
      line_colour_q <= line_colour_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      flags_q         <= flags_d;
      pixel_x_q       <= pixel_x_d;
      pixel_y_q       <= pixel_y_d;
      pixel_color_q   <= pixel_color_d;
      pixel_address_q <= pixel_address_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign valid_res_o     = flags_q.valid_res;
  assign last_o          = flags_q.last;
  assign pixel_x_o       = pixel_x_q;
  assign pixel_y_o       = pixel_y_q;
  assign pixel_color_o   = pixel_color_q;
  assign pixel_address_o = pixel_address_q;

`ifndef ASSERT_OFF
  // the final pixel ends the line
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && flags_d.last) |=> !active_q)
    else $error("line still active after last pixel");

  // error term never rests above zero
  a_err_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_term_q[EW-1] || (error_term_q == '0))
    else $error("error term positive");

  a_major_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (major_pos_q <= major_end_q) && (minor_delta_q <= major_delta_q))
    else $error("active line state out of range");

  // a stalled input item is not dropped
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item lost under stall");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (!last_o && (pixel_address_o == '0)))
    else $error("no-pixel result carries data");
`endif

endmodule
